// ===== src/crcfd_pkg.sv =====
// crcfd_pkg: shared types, constants and the crc16 byte step for the
// crc framed request deframer; no dependencies
package crcfd_pkg;

  localparam int unsigned MaxPayload = 64;

  localparam logic [7:0]  SyncByte     = 8'hA5;
  localparam logic [7:0]  TypeSet      = 8'h01;
  localparam logic [7:0]  TypeGet      = 8'h02;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [19:0] TimeoutReset = 20'd100000;
  localparam logic [6:0]  CapReset     = 7'd64;
  localparam logic [19:0] TickMax      = 20'hFFFFF;
  localparam int unsigned HdrBytes     = 7;

  localparam int unsigned AddrW = 3;
  localparam logic [0:0] RegCap     = 1'b0;
  localparam logic [0:0] RegTimeout = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC, PH_TYPE, PH_HEADER, PH_PAYLOAD, PH_CRC
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK, ST_CRC_ERR, ST_OVERSIZE
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD, KIND_DONE
  } kind_e;

  typedef struct packed {
    logic [6:0]  payload_cap;
    logic [19:0] frame_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic        is_get;
    logic [7:0]  request;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic [15:0] payload_offset;
    logic [7:0]  payload_data;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

endpackage

// ===== src/crcfd_cfg.sv =====
// crcfd_cfg: apb register file for payload cap and frame timeout
// depends on crcfd_pkg
module crcfd_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [crcfd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output crcfd_pkg::cfg_t         cfg_o
);
  import crcfd_pkg::*;

  cfg_t       cfg_q;
  logic [0:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_cap         <= CapReset;
      cfg_q.frame_timeout_ticks <= TimeoutReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegCap:     cfg_q.payload_cap         <= pwdata[6:0];
        RegTimeout: cfg_q.frame_timeout_ticks <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCap:     prdata = {25'd0, cfg_q.payload_cap};
      RegTimeout: prdata = {12'd0, cfg_q.frame_timeout_ticks};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/crcfd_core.sv =====
// crcfd_core: input register, framing state, crc check and result build
// depends on crcfd_pkg
module crcfd_core #(
  parameter int unsigned PayloadMax = crcfd_pkg::MaxPayload
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cmd_i,
  input  logic [7:0]      data_byte_i,
  input  crcfd_pkg::cfg_t cfg_i,
  input  logic            out_free_i,
  output logic            res_valid_o,
  output crcfd_pkg::res_t res_o
);
  import crcfd_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic        cmd_q;
  logic [7:0]  byte_q;
  logic        step;

  phase_e      phase_q, phase_d;
  logic        get_q, get_d;
  logic [7:0]  hdr_q [HdrBytes];
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] pay_cnt_q, pay_cnt_d;
  logic        discard_q, discard_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        crc_cnt_q, crc_cnt_d;
  logic [19:0] idle_q, idle_d;
  logic        hdr_we;

  logic [15:0] len_now;
  logic [15:0] cap;
  logic [15:0] pay_next;
  logic [15:0] crc_upd;

  assign step       = in_valid_q & out_free_i;
  assign in_ready_o = ~in_valid_q | out_free_i;
  assign in_valid_d = (in_valid_i & in_ready_o) | (in_valid_q & ~step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i & in_ready_o) begin
      cmd_q  <= cmd_i;
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_cnt_q] <= byte_q;
    end
  end

  assign len_now  = {byte_q, hdr_q[5]};
  assign cap      = (16'(cfg_i.payload_cap) < 16'(PayloadMax)) ?
                    16'(cfg_i.payload_cap) : 16'(PayloadMax);
  assign pay_next = pay_cnt_q + 16'd1;
  assign crc_upd  = crc_byte(crc_q, byte_q);

  always_comb begin
    phase_d   = phase_q;
    get_d     = get_q;
    hdr_cnt_d = hdr_cnt_q;
    pay_cnt_d = pay_cnt_q;
    discard_d = discard_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    crc_cnt_d = crc_cnt_q;
    idle_d    = idle_q;
    hdr_we    = 1'b0;
    if (step) begin
      if (cmd_q) begin
        if (idle_q != TickMax) begin
          idle_d = idle_q + 20'd1;
        end
        if (phase_q != PH_SYNC && idle_d > cfg_i.frame_timeout_ticks) begin
          phase_d   = PH_SYNC;
          hdr_cnt_d = 3'd0;
          pay_cnt_d = 16'd0;
          discard_d = 1'b0;
          crc_cnt_d = 1'b0;
        end
      end else begin
        idle_d = 20'd0;
        case (phase_q)
          PH_TYPE: begin
            if (byte_q == TypeSet || byte_q == TypeGet) begin
              get_d     = (byte_q == TypeGet);
              crc_d     = crc_byte(CrcInit, byte_q);
              hdr_cnt_d = 3'd0;
              phase_d   = PH_HEADER;
            end else begin
              phase_d = PH_SYNC;
            end
          end
          PH_HEADER: begin
            hdr_we    = 1'b1;
            crc_d     = crc_upd;
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            if (hdr_cnt_q == 3'(HdrBytes - 1)) begin
              hdr_cnt_d = 3'd0;
              pay_cnt_d = 16'd0;
              discard_d = 1'b0;
              crc_cnt_d = 1'b0;
              if (get_q || len_now == 16'd0) begin
                phase_d = PH_CRC;
              end else begin
                discard_d = (len_now > cap);
                phase_d   = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_d     = crc_upd;
            pay_cnt_d = pay_next;
            if (pay_next == {hdr_q[6], hdr_q[5]}) begin
              crc_cnt_d = 1'b0;
              phase_d   = PH_CRC;
            end
          end
          PH_CRC: begin
            if (!crc_cnt_q) begin
              crc_lo_d  = byte_q;
              crc_cnt_d = 1'b1;
            end else begin
              phase_d   = PH_SYNC;
              hdr_cnt_d = 3'd0;
              pay_cnt_d = 16'd0;
              discard_d = 1'b0;
              crc_cnt_d = 1'b0;
            end
          end
          default: begin
            phase_d = (byte_q == SyncByte) ? PH_TYPE : PH_SYNC;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid_o          = 1'b0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.status         = ST_OK;
    res_o.is_get         = get_q;
    res_o.request        = hdr_q[0];
    res_o.value_word     = {hdr_q[2], hdr_q[1]};
    res_o.index_word     = {hdr_q[4], hdr_q[3]};
    res_o.length_word    = {hdr_q[6], hdr_q[5]};
    res_o.payload_offset = 16'd0;
    res_o.payload_data   = 8'd0;
    if (step && !cmd_q) begin
      case (phase_q)
        PH_PAYLOAD: begin
          res_valid_o          = ~discard_q;
          res_o.payload_offset = pay_cnt_q;
          res_o.payload_data   = byte_q;
        end
        PH_CRC: begin
          if (crc_cnt_q) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_DONE;
            if ({byte_q, crc_lo_q} != crc_q) begin
              res_o.status = ST_CRC_ERR;
            end else if (discard_q) begin
              res_o.status = ST_OVERSIZE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC;
      get_q     <= 1'b0;
      hdr_cnt_q <= 3'd0;
      pay_cnt_q <= 16'd0;
      discard_q <= 1'b0;
      crc_q     <= CrcInit;
      crc_lo_q  <= 8'd0;
      crc_cnt_q <= 1'b0;
      idle_q    <= 20'd0;
    end else begin
      phase_q   <= phase_d;
      get_q     <= get_d;
      hdr_cnt_q <= hdr_cnt_d;
      pay_cnt_q <= pay_cnt_d;
      discard_q <= discard_d;
      crc_q     <= crc_d;
      crc_lo_q  <= crc_lo_d;
      crc_cnt_q <= crc_cnt_d;
      idle_q    <= idle_d;
    end
  end

endmodule

// ===== src/crcfd_outreg.sv =====
// crcfd_outreg: result register between the core and the output channel
// depends on crcfd_pkg
module crcfd_outreg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  input  crcfd_pkg::res_t res_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output crcfd_pkg::res_t res_o
);
  import crcfd_pkg::*;

  logic out_valid_q, out_valid_d;
  res_t res_q;

  assign free_o      = ~out_valid_q | out_ready_i;
  assign out_valid_d = res_valid_i | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== src/crc_framed_request_deframer_top.sv =====
// crc_framed_request_deframer_top: sync/crc16 framed request deframer
// depends on crcfd_pkg, crcfd_cfg, crcfd_core, crcfd_outreg
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   cmd_i, data_byte_i
//   out      out_valid_o / out_ready_i kind_o .. payload_data_o
//   cfg      apb psel/penable/pready   paddr, pwdata, prdata
//
// one transaction per cycle sustained while the output side accepts; a transaction
// is held in the input register, is processed in one pass, and its result lands
// in the output register, which presents it on the out channel
// reset clears framing state, counters and the valid flags
// a stalled output register holds the input register, which then holds in_ready_o low
module crc_framed_request_deframer_top #(
  parameter int unsigned PayloadMax = crcfd_pkg::MaxPayload
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [1:0]  status_o,
  output logic        is_get_o,
  output logic [7:0]  request_o,
  output logic [15:0] value_word_o,
  output logic [15:0] index_word_o,
  output logic [15:0] length_word_o,
  output logic [15:0] payload_offset_o,
  output logic [7:0]  payload_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [crcfd_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import crcfd_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic core_res_valid;
  logic out_free;

  crcfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  crcfd_core #(
    .PayloadMax (PayloadMax)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg),
    .out_free_i  (out_free),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  crcfd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (core_res_valid),
    .res_i       (core_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o           = out_res.kind;
  assign status_o         = out_res.status;
  assign is_get_o         = out_res.is_get;
  assign request_o        = out_res.request;
  assign value_word_o     = out_res.value_word;
  assign index_word_o     = out_res.index_word;
  assign length_word_o    = out_res.length_word;
  assign payload_offset_o = out_res.payload_offset;
  assign payload_data_o   = out_res.payload_data;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for crc_framed_request_deframer_top, directed table then random frames
// depends on crcfd_pkg and the deframer rtl; checks every output against table rows or a model
module tb;
  import crcfd_pkg::*;

  typedef enum logic [2:0] {
    ROW_BYTE, ROW_TICK, ROW_CRC_LO, ROW_CRC_HI, ROW_CRC_BAD_HI
  } row_e;

  typedef struct packed {
    row_e       op;
    logic [7:0] data;
    bit         typed;
    res_t       res;
  } row_t;

  localparam logic [AddrW-1:0] CapAddr     = {RegCap, 2'b00};
  localparam logic [AddrW-1:0] TimeoutAddr = {RegTimeout, 2'b00};

  localparam res_t NoRes = '0;
  localparam res_t GetDoneOk = '{kind: KIND_DONE, status: ST_OK, is_get: 1'b1,
    request: 8'hFF, value_word: 16'hFFFF, index_word: 16'h0000, length_word: 16'hFFFF,
    payload_offset: 16'h0000, payload_data: 8'h00};
  localparam res_t SetPayFF = '{kind: KIND_PAYLOAD, status: ST_OK, is_get: 1'b0,
    request: 8'h00, value_word: 16'h0000, index_word: 16'hFFFF, length_word: 16'h0001,
    payload_offset: 16'h0000, payload_data: 8'hFF};
  localparam res_t SetDoneCrcErr = '{kind: KIND_DONE, status: ST_CRC_ERR, is_get: 1'b0,
    request: 8'h00, value_word: 16'h0000, index_word: 16'hFFFF, length_word: 16'h0001,
    payload_offset: 16'h0000, payload_data: 8'h00};

  localparam row_t DirRows [27] = '{
    '{ROW_BYTE, 8'hA5, 1'b0, NoRes},
    '{ROW_BYTE, 8'hA5, 1'b0, NoRes},
    '{ROW_BYTE, 8'h01, 1'b0, NoRes},
    '{ROW_BYTE, 8'hA5, 1'b0, NoRes},
    '{ROW_BYTE, 8'h02, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_TICK, 8'hA5, 1'b0, NoRes},
    '{ROW_BYTE, 8'h00, 1'b0, NoRes},
    '{ROW_BYTE, 8'h00, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_CRC_LO, 8'h00, 1'b0, NoRes},
    '{ROW_CRC_HI, 8'h00, 1'b1, GetDoneOk},
    '{ROW_BYTE, 8'hA5, 1'b0, NoRes},
    '{ROW_BYTE, 8'h01, 1'b0, NoRes},
    '{ROW_BYTE, 8'h00, 1'b0, NoRes},
    '{ROW_BYTE, 8'h00, 1'b0, NoRes},
    '{ROW_BYTE, 8'h00, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b0, NoRes},
    '{ROW_BYTE, 8'h01, 1'b0, NoRes},
    '{ROW_BYTE, 8'h00, 1'b0, NoRes},
    '{ROW_BYTE, 8'hFF, 1'b1, SetPayFF},
    '{ROW_CRC_LO, 8'h00, 1'b0, NoRes},
    '{ROW_CRC_BAD_HI, 8'h00, 1'b1, SetDoneCrcErr}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                cmd_i = 1'b0;
  logic [7:0]          data_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                kind_o;
  logic [1:0]          status_o;
  logic                is_get_o;
  logic [7:0]          request_o;
  logic [15:0]         value_word_o;
  logic [15:0]         index_word_o;
  logic [15:0]         length_word_o;
  logic [15:0]         payload_offset_o;
  logic [7:0]          payload_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  crc_framed_request_deframer_top u_top (.*);

  // local copy of the deframer state and registers
  logic [6:0]  cfg_cap;
  logic [19:0] cfg_timeout;
  phase_e      fr_phase;
  logic        fr_get;
  logic [7:0]  fr_hdr [7];
  int unsigned fr_hcnt;
  logic [15:0] fr_pcnt;
  logic        fr_discard;
  logic [15:0] fr_crc;
  logic [7:0]  fr_crc_lo;
  logic        fr_crc_half;
  logic [19:0] fr_idle;

  res_t exp_results [$];
  res_t want_res;
  int   mismatch_count = 0;
  int   in_idle_max = 6;
  int   out_idle_max = 6;
  int   tick_span = 3;
  int   rand_items = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      r = (r[15] ^ b[i]) ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic res_t frame_view(input kind_e k, input status_e st,
                                      input logic [15:0] offset, input logic [7:0] data);
    res_t r;
    r.kind           = k;
    r.status         = st;
    r.is_get         = fr_get;
    r.request        = fr_hdr[0];
    r.value_word     = {fr_hdr[2], fr_hdr[1]};
    r.index_word     = {fr_hdr[4], fr_hdr[3]};
    r.length_word    = {fr_hdr[6], fr_hdr[5]};
    r.payload_offset = offset;
    r.payload_data   = data;
    return r;
  endfunction

  task automatic abandon_frame();
    fr_phase    = PH_SYNC;
    fr_hcnt     = 0;
    fr_pcnt     = '0;
    fr_discard  = 1'b0;
    fr_crc_half = 1'b0;
  endtask

  task automatic deframe_step(input logic c, input logic [7:0] b,
                              output bit got, output res_t r);
    logic [15:0] len;
    int unsigned cap_lim;
    status_e     st;
    got = 1'b0;
    r = '0;
    len = {fr_hdr[6], fr_hdr[5]};
    if (c) begin
      if (fr_idle != TickMax) fr_idle++;
      if (fr_phase != PH_SYNC && fr_idle > cfg_timeout) abandon_frame();
      return;
    end
    fr_idle = '0;
    case (fr_phase)
      PH_TYPE: begin
        if (b == TypeSet || b == TypeGet) begin
          fr_get   = (b == TypeGet);
          fr_crc   = crc16_next(CrcInit, b);
          fr_hcnt  = 0;
          fr_phase = PH_HEADER;
        end else begin
          fr_phase = PH_SYNC;
        end
      end
      PH_HEADER: begin
        fr_hdr[fr_hcnt] = b;
        fr_crc = crc16_next(fr_crc, b);
        fr_hcnt++;
        if (fr_hcnt >= HdrBytes) begin
          fr_hcnt     = 0;
          fr_pcnt     = '0;
          fr_discard  = 1'b0;
          fr_crc_half = 1'b0;
          len = {fr_hdr[6], fr_hdr[5]};
          if (fr_get || len == 16'd0) begin
            fr_phase = PH_CRC;
          end else begin
            cap_lim = (cfg_cap < MaxPayload) ? cfg_cap : MaxPayload;
            if (len > cap_lim) fr_discard = 1'b1;
            fr_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        fr_crc = crc16_next(fr_crc, b);
        if (!fr_discard) begin
          got = 1'b1;
          r = frame_view(KIND_PAYLOAD, ST_OK, fr_pcnt, b);
        end
        fr_pcnt = fr_pcnt + 16'd1;
        if (fr_pcnt == len) begin
          fr_crc_half = 1'b0;
          fr_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        if (!fr_crc_half) begin
          fr_crc_lo   = b;
          fr_crc_half = 1'b1;
        end else begin
          if ({b, fr_crc_lo} != fr_crc) st = ST_CRC_ERR;
          else if (fr_discard) st = ST_OVERSIZE;
          else st = ST_OK;
          got = 1'b1;
          r = frame_view(KIND_DONE, st, 16'h0000, 8'h00);
          abandon_frame();
        end
      end
      default: fr_phase = (b == SyncByte) ? PH_TYPE : PH_SYNC;
    endcase
  endtask

  // drive one input transaction, then update the local model on acceptance
  task automatic feed(input logic c, input logic [7:0] d,
                      input bit typed = 1'b0, input res_t typed_res = '0);
    int   gap;
    bit   got;
    res_t r;
    gap = $urandom_range(0, in_idle_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    data_byte_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    deframe_step(c, d, got, r);
    if (typed) exp_results.push_back(typed_res);
    else if (got) exp_results.push_back(r);
  endtask

  task automatic frame_byte(input logic [7:0] b);
    int n;
    if ($urandom_range(0, 15) == 0) begin
      n = $urandom_range(1, tick_span);
      repeat (n) begin
        feed(1'b1, 8'($urandom));
        rand_items++;
      end
    end
    feed(1'b0, b);
    rand_items++;
  endtask

  task automatic send_frame();
    logic [7:0]  body [$];
    logic [7:0]  type_byte;
    logic [15:0] len;
    logic [15:0] val;
    logic [15:0] idx;
    logic [15:0] crc_word;
    bit          is_get;
    int          trunc;
    in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
    out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
    repeat ($urandom_range(0, 2)) feed(1'b0, 8'($urandom));
    is_get = ($urandom_range(0, 2) == 0);
    type_byte = is_get ? TypeGet : TypeSet;
    if ($urandom_range(0, 15) == 0) type_byte = 8'($urandom);
    val = 16'($urandom);
    idx = 16'($urandom);
    if (is_get) begin
      len = 16'($urandom);
    end else begin
      case ($urandom_range(0, 7))
        0: len = 16'd0;
        1: len = 16'($urandom_range(50, 70));
        2: len = 16'($urandom_range(65, 100));
        default: len = 16'($urandom_range(1, 12));
      endcase
    end
    body = {SyncByte, type_byte, 8'($urandom), val[7:0], val[15:8],
            idx[7:0], idx[15:8], len[7:0], len[15:8]};
    if (!is_get) repeat (len) body.push_back(8'($urandom));
    trunc = ($urandom_range(0, 15) == 0) ? $urandom_range(1, body.size()) : -1;
    foreach (body[i]) begin
      if (i == trunc) return;
      frame_byte(body[i]);
    end
    crc_word = fr_crc;
    if ($urandom_range(0, 7) == 0) crc_word ^= 16'(1 << $urandom_range(0, 15));
    frame_byte(crc_word[7:0]);
    frame_byte(crc_word[15:8]);
  endtask

  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == CapAddr) cfg_cap = value[6:0];
    else if (addr == TimeoutAddr) cfg_timeout = value[19:0];
  endtask

  // idle the input side and let every pending transaction come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (exp_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_results.size() == 0) begin
        report_mismatch("output transaction with nothing expected");
      end else begin
        want_res = exp_results.pop_front();
        check_field("kind", kind_o, want_res.kind);
        check_field("status", status_o, want_res.status);
        check_field("is_get", is_get_o, want_res.is_get);
        check_field("request", request_o, want_res.request);
        check_field("value_word", value_word_o, want_res.value_word);
        check_field("index_word", index_word_o, want_res.index_word);
        check_field("length_word", length_word_o, want_res.length_word);
        check_field("payload_offset", payload_offset_o, want_res.payload_offset);
        check_field("payload_data", payload_data_o, want_res.payload_data);
      end
    end
  end

  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, out_idle_max);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [7:0]  d;
    logic [31:0] word;
    logic [6:0]  cap;
    logic [19:0] tmo;
    int          p;
    int          start;
    cfg_cap     = CapReset;
    cfg_timeout = TimeoutReset;
    fr_get      = 1'b0;
    fr_crc      = CrcInit;
    fr_crc_lo   = 8'h00;
    fr_idle     = '0;
    foreach (fr_hdr[i]) fr_hdr[i] = 8'h00;
    abandon_frame();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DirRows); i++) begin
      case (DirRows[i].op)
        ROW_CRC_LO:     d = fr_crc[7:0];
        ROW_CRC_HI:     d = fr_crc[15:8];
        ROW_CRC_BAD_HI: d = ~fr_crc[15:8];
        default:        d = DirRows[i].data;
      endcase
      feed(DirRows[i].op == ROW_TICK, d, DirRows[i].typed, DirRows[i].res);
    end

    p = 0;
    while (rand_items < 1000) begin
      drain();
      case (p % 6)
        0: begin cap = 7'd0;   tmo = TickMax; end
        1: begin cap = 7'd127; tmo = 20'd1; end
        2: begin cap = 7'd64;  tmo = 20'd0; end
        3: begin cap = 7'($urandom_range(0, 127)); tmo = 20'($urandom_range(1, 20)); end
        4: begin cap = 7'd63;  tmo = TimeoutReset; end
        default: begin cap = 7'd1; tmo = 20'd3; end
      endcase
      word = $urandom;
      word[6:0] = cap;
      reg_write(CapAddr, word);
      word = $urandom;
      word[19:0] = tmo;
      reg_write(TimeoutAddr, word);
      tick_span = (tmo <= 20'd20) ? int'(tmo) + 2 : 3;
      start = rand_items;
      while (rand_items - start < 170) send_frame();
      p++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
